// File: design/newton_nth_root_assert.svh
// Assertion macros for the newton_nth_root checker.
// Depends on: signals named clk and rst_n in the scope of each use.
`ifndef NEWTON_NTH_ROOT_ASSERT_SVH
`define NEWTON_NTH_ROOT_ASSERT_SVH

// same-cycle implication
`define NNR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("newton_nth_root: check failed");

// next-cycle implication
`define NNR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("newton_nth_root: check failed");

`endif

// File: design/nnr_pkg.sv
// Shared types and constants for the Newton nth-root block.
// No dependencies.
`default_nettype none

package nnr_pkg;

  localparam int DEF_MAX_EXP = 15;
  localparam logic [11:0] ITER_RESET = 12'd1000;

  localparam logic signed [31:0] FIX_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXP_ZERO = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVF      = 2'd3;

  // divider geometry
  localparam int DVD_W      = 48;   // |x| * 2^16
  localparam int DVS_W      = 32;
  localparam int LONG_BITS  = 48;
  localparam int SHORT_BITS = 33;   // |t - a| fits in 33 bits
  localparam int CNT_W      = 6;

  typedef struct packed {
    logic signed [31:0] radicand;
    logic [3:0]         exponent;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] root;
    logic signed [31:0] residual;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic             short_mode;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: design/nnr_mul.sv
// Q16.16 multiplier: registered 32x32 product, floor shift by 16, saturate.
// Depends on: nnr_pkg.
`default_nettype none

module nnr_mul
  import nnr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [31:0] x,
  input  wire logic signed [31:0] y,
  output logic signed [31:0]      res,
  output logic                    sat
);

  logic signed [63:0] prod_r;
  logic signed [63:0] shifted;

  always_ff @(posedge clk) begin
    prod_r <= 64'(x) * 64'(y);
  end

  // arithmetic shift rounds toward minus infinity
  assign shifted = prod_r >>> 16;

  always_comb begin
    sat = 1'b0;
    res = shifted[31:0];
    if (!shifted[63] && (shifted[62:31] != '0)) begin
      sat = 1'b1;
      res = S32_MAX;
    end else if (shifted[63] && (shifted[62:31] != '1)) begin
      sat = 1'b1;
      res = S32_MIN;
    end
  end

endmodule

`default_nettype wire

// File: design/nnr_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Long mode: 48-bit dividend. Short mode: 33-bit dividend. Depends on: nnr_pkg.
`default_nettype none

module nnr_div
  import nnr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             qbit;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = !diff[DVS_W];   // no borrow: trial >= divisor

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.short_mode ? CNT_W'(SHORT_BITS) : CNT_W'(LONG_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
      dvd_r <= req.short_mode ?
               {req.dividend[SHORT_BITS-1:0], {(DVD_W-SHORT_BITS){1'b0}}} :
               req.dividend;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], qbit};
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// File: design/newton_nth_root.sv
// Newton-Raphson nth root of a signed Q16.16 value. One word in, one word out.
// A word is taken when start is high and busy is low; the result appears on
// out_data for exactly one cycle with out_valid high and cannot be stalled, so
// the receiver must take it then. Exponent zero answers on the next cycle with
// status 1. Otherwise the estimate starts at 1.0 and runs iteration_count
// Newton steps on one shared multiplier and one shared bit-serial divider.
// Each step forms a^(n-1) by repeated multiply (1.0 when n = 1), divides q by
// it on the divider in long mode, then divides t - a by n in short mode. The
// residual pass forms a^n by repeated multiply. The reset count is 1000. busy
// stays high for the whole of an item with a nonzero exponent; the config write
// port is ready only while busy is low. Depends on: nnr_pkg, nnr_mul, nnr_div.
`default_nettype none

module newton_nth_root
  import nnr_pkg::*;
#(
  parameter int MAX_EXP = DEF_MAX_EXP
)(
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input word
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_data,
  // result word
  output logic           out_valid,
  output out_word_t      out_data,
  // iteration count register
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [11:0] cfg_data
);

  // exponent register width: holds 4-bit input and the clamp value
  localparam int NW = ($clog2(MAX_EXP + 1) > 4) ? $clog2(MAX_EXP + 1) : 4;
  localparam logic [NW-1:0] MAXN = NW'(MAX_EXP);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STEP  = 4'd1;   // set up a^(n-1) or the final a^n
  localparam logic [3:0] S_POW   = 4'd2;   // issue next multiply or move on
  localparam logic [3:0] S_MULW  = 4'd3;   // take product
  localparam logic [3:0] S_DIVQ  = 4'd4;   // start q / a^(n-1)
  localparam logic [3:0] S_DIVQW = 4'd5;
  localparam logic [3:0] S_DIVN  = 4'd6;   // start (t - a) / n
  localparam logic [3:0] S_DIVNW = 4'd7;
  localparam logic [3:0] S_RES   = 4'd8;   // residual and result word

  logic [3:0]         state_r, state_nxt;
  logic [11:0]        iter_r;
  logic [11:0]        step_r, step_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [NW-1:0]      left_r, left_nxt;     // multiplies still to do
  logic               fin_r, fin_nxt;       // power is for the residual
  logic               ovf_r, ovf_nxt;
  logic               dz_r, dz_nxt;
  logic               neg_r, neg_nxt;       // sign of t - a
  logic signed [31:0] q_r, q_nxt;
  logic signed [31:0] a_r, a_nxt;
  logic signed [31:0] b_r, b_nxt;           // running power
  logic signed [31:0] t_r, t_nxt;           // quotient q / a^(n-1)
  logic               ov_r, ov_nxt;         // out_valid
  out_word_t          out_r, out_nxt;

  logic signed [31:0] mul_res;
  logic               mul_sat;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // combinational helpers
  logic [NW-1:0]      exp_ext;
  logic [NW-1:0]      exp_clamped;
  logic [31:0]        q_mag;
  logic [31:0]        b_mag;
  logic               q_neg;
  logic signed [32:0] d_ta;
  logic [32:0]        d_mag;
  logic [32:0]        qn_mag;
  logic signed [34:0] u_ext;
  logic signed [34:0] a_sum;
  logic signed [32:0] res_diff;
  logic signed [32:0] zero_diff;

  nnr_mul u_mul (
    .clk (clk),
    .x   (b_r),
    .y   (a_r),
    .res (mul_res),
    .sat (mul_sat)
  );

  nnr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign exp_ext     = NW'(in_data.exponent);
  assign exp_clamped = (exp_ext > MAXN) ? MAXN : exp_ext;

  assign q_mag  = q_r[31] ? 32'(-q_r) : 32'(q_r);
  assign b_mag  = b_r[31] ? 32'(-b_r) : 32'(b_r);
  assign q_neg  = q_r[31] ^ b_r[31];

  assign d_ta   = {t_r[31], t_r} - {a_r[31], a_r};
  assign d_mag  = d_ta[32] ? 33'(-d_ta) : 33'(d_ta);
  assign qn_mag = div_rsp.quotient[32:0];
  assign u_ext  = neg_r ? -$signed({2'b00, qn_mag}) : $signed({2'b00, qn_mag});
  assign a_sum  = {{3{a_r[31]}}, a_r} + u_ext;

  assign res_diff  = {q_r[31], q_r} - {b_r[31], b_r};
  assign zero_diff = {in_data.radicand[31], in_data.radicand} - {FIX_ONE[31], FIX_ONE};

  // divider requests come straight from the sequencer state
  always_comb begin
    div_req.start      = 1'b0;
    div_req.short_mode = 1'b0;
    div_req.dividend   = {q_mag, 16'h0000};
    div_req.divisor    = b_mag;
    unique case (state_r)
      S_DIVQ: begin
        div_req.start = (b_r != '0);
      end
      S_DIVN: begin
        div_req.start      = 1'b1;
        div_req.short_mode = 1'b1;
        div_req.dividend   = DVD_W'(d_mag);
        div_req.divisor    = DVS_W'(n_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    n_nxt     = n_r;
    left_nxt  = left_r;
    fin_nxt   = fin_r;
    ovf_nxt   = ovf_r;
    dz_nxt    = dz_r;
    neg_nxt   = neg_r;
    q_nxt     = q_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    t_nxt     = t_r;
    ov_nxt    = 1'b0;
    out_nxt   = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.exponent == 4'd0) begin
            // no iteration: root 0, residual q - 1.0
            ov_nxt          = 1'b1;
            out_nxt.root    = '0;
            out_nxt.status  = ST_EXP_ZERO;
            if (zero_diff[32] != zero_diff[31]) begin
              out_nxt.residual = zero_diff[32] ? S32_MIN : S32_MAX;
            end else begin
              out_nxt.residual = zero_diff[31:0];
            end
          end else begin
            q_nxt     = in_data.radicand;
            n_nxt     = exp_clamped;
            a_nxt     = FIX_ONE;
            step_nxt  = iter_r;
            ovf_nxt   = 1'b0;
            dz_nxt    = 1'b0;
            state_nxt = S_STEP;
          end
        end
      end

      S_STEP: begin
        state_nxt = S_POW;
        if (step_r == '0) begin
          // final a^n for the residual
          fin_nxt  = 1'b1;
          b_nxt    = a_r;
          left_nxt = n_r - NW'(1);
        end else begin
          fin_nxt = 1'b0;
          if (n_r == NW'(1)) begin
            b_nxt    = FIX_ONE;
            left_nxt = '0;
          end else begin
            b_nxt    = a_r;
            left_nxt = n_r - NW'(2);
          end
        end
      end

      S_POW: begin
        if (left_r == '0) begin
          state_nxt = fin_r ? S_RES : S_DIVQ;
        end else begin
          state_nxt = S_MULW;   // multiplier registers b_r * a_r this cycle
        end
      end

      S_MULW: begin
        b_nxt     = mul_res;
        ovf_nxt   = ovf_r | mul_sat;
        left_nxt  = left_r - NW'(1);
        state_nxt = S_POW;
      end

      S_DIVQ: begin
        if (b_r == '0) begin
          dz_nxt    = 1'b1;
          state_nxt = S_DIVN;
          if (q_r == '0) begin
            t_nxt = '0;
          end else begin
            t_nxt = q_r[31] ? S32_MIN : S32_MAX;
          end
        end else begin
          state_nxt = S_DIVQW;
        end
      end

      S_DIVQW: begin
        if (div_rsp.done) begin
          state_nxt = S_DIVN;
          if (!q_neg) begin
            if (div_rsp.quotient > 48'h0000_7FFF_FFFF) begin
              t_nxt   = S32_MAX;
              ovf_nxt = 1'b1;
            end else begin
              t_nxt = div_rsp.quotient[31:0];
            end
          end else begin
            if (div_rsp.quotient > 48'h0000_8000_0000) begin
              t_nxt   = S32_MIN;
              ovf_nxt = 1'b1;
            end else begin
              t_nxt = 32'(-div_rsp.quotient[31:0]);
            end
          end
        end
      end

      S_DIVN: begin
        neg_nxt   = d_ta[32];
        state_nxt = S_DIVNW;
      end

      S_DIVNW: begin
        if (div_rsp.done) begin
          step_nxt  = step_r - 12'd1;
          state_nxt = S_STEP;
          if (a_sum[34:31] != 4'b0000 && a_sum[34:31] != 4'b1111) begin
            a_nxt   = a_sum[34] ? S32_MIN : S32_MAX;
            ovf_nxt = 1'b1;
          end else begin
            a_nxt = a_sum[31:0];
          end
        end
      end

      S_RES: begin
        ov_nxt       = 1'b1;
        out_nxt.root = a_r;
        state_nxt    = S_IDLE;
        if (res_diff[32] != res_diff[31]) begin
          out_nxt.residual = res_diff[32] ? S32_MIN : S32_MAX;
          ovf_nxt          = 1'b1;
        end else begin
          out_nxt.residual = res_diff[31:0];
        end
        // division by zero wins over overflow
        priority if (dz_r) begin
          out_nxt.status = ST_DIV_ZERO;
        end else if (ovf_nxt) begin
          out_nxt.status = ST_OVF;
        end else begin
          out_nxt.status = ST_OK;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      iter_r  <= ITER_RESET;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        iter_r <= cfg_data;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    n_r    <= n_nxt;
    left_r <= left_nxt;
    fin_r  <= fin_nxt;
    ovf_r  <= ovf_nxt;
    dz_r   <= dz_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    t_r    <= t_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: design/nnr_checker.sv
// Port-level checks for newton_nth_root, bound to the top level.
// Depends on: nnr_pkg, newton_nth_root_assert.svh.
`default_nettype none

`include "newton_nth_root_assert.svh"

module nnr_checker
  import nnr_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire in_word_t   in_data,
  input wire logic       out_valid,
  input wire out_word_t  out_data
);

  // exponent zero answers next cycle with its own status and a zero root
  `NNR_ASSERT_NXT(a_exp_zero, start && !busy && (in_data.exponent == 4'd0), out_valid && (out_data.status == ST_EXP_ZERO) && (out_data.root == '0))

  // a real root computation holds the block
  `NNR_ASSERT_NXT(a_takes_busy, start && !busy && (in_data.exponent != 4'd0), busy)

  // the block is free again while its result word shows
  `NNR_ASSERT_IMP(a_free_on_out, out_valid, !busy)

  // every finished computation strobes its word as busy drops
  `NNR_ASSERT_IMP(a_done_strobe, $fell(busy), out_valid)

endmodule

bind newton_nth_root nnr_checker u_nnr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
